// ===== hdl/cpk_pkg.sv =====
`timescale 1ns / 1ps

package cpk_pkg;

    // Parameter default
    localparam int MAX_RADIUS_DEF = 15;

    // Configuration register indexes
    localparam logic [2:0] REG_RADIUS   = 3'd0;
    localparam logic [2:0] REG_SIN_1    = 3'd1;
    localparam logic [2:0] REG_COS_1    = 3'd2;
    localparam logic [2:0] REG_SIN_2    = 3'd3;
    localparam logic [2:0] REG_COS_2    = 3'd4;
    localparam logic [2:0] REG_QUADRANT = 3'd5;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_ROW  = 2'd1;
    localparam logic [1:0] STAT_SUM_ZERO = 2'd2;

    // Datapath widths
    localparam int DIV_W   = 64;
    localparam int DCNT_W  = 6;
    localparam int MUL_W   = 32;

    // Quotient widths of the two divides
    localparam logic [DCNT_W-1:0] V_QBITS    = 6'd27;
    localparam logic [DCNT_W-1:0] COEF_QBITS = 6'd17;

    // Reciprocals for floor(v3/6) and floor(v4/24)
    localparam logic [MUL_W-1:0] RECIP6   = 32'd699051;
    localparam int               RECIP6_SH  = 22;
    localparam logic [MUL_W-1:0] RECIP24  = 32'd43691;
    localparam int               RECIP24_SH = 20;

    localparam int SQUARINGS = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AX1,
        ST_AX2,
        ST_DIVV,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_SQ1,
        ST_SQ2,
        ST_WDONE,
        ST_DIVQ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     num;
        logic [DIV_W-1:0]     den;
        logic [DCNT_W-1:0]    qbits;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quo;
    } div_rsp_t;

endpackage

// ===== hdl/cpk_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, quotient must fit in qbits
module cpk_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  cpk_pkg::div_req_t  req,
    output cpk_pkg::div_rsp_t  rsp
);

    logic [cpk_pkg::DIV_W-1:0]  rem_reg;
    logic [cpk_pkg::DIV_W-1:0]  dsh_reg;
    logic [cpk_pkg::DIV_W-1:0]  quo_reg;
    logic [cpk_pkg::DCNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic                       fits;

    assign fits = (rem_reg >= dsh_reg);

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == cpk_pkg::DCNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: shift divisor down, subtract where it fits
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.num;
            dsh_reg <= req.den << (req.qbits - cpk_pkg::DCNT_W'(1));
            quo_reg <= '0;
            cnt_reg <= req.qbits;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[cpk_pkg::DIV_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - cpk_pkg::DCNT_W'(1);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== hdl/corner_prototype_kernel_gen.sv =====
`timescale 1ns / 1ps

// Sequence: a bad row's result is valid in the cycle after accept. Otherwise each kernel
// position outside the quadrant takes the two axis checks, and one inside it also takes
// a divide, the multiplies of the series and the repeated squarings, over all (2r+1)^2
// positions; then the same again plus a divide per emitted column.
// Throughput: one request at a time; the shared multiplier and divider set the pace.
// Reset: synchronous, active low; registers return to radius 4, quadrant 0, axes 0/90 deg.
module corner_prototype_kernel_gen #(
    parameter int MAX_RADIUS = cpk_pkg::MAX_RADIUS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // row_index[4:0]
    input  logic [7:0]  s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // coefficient[16:0], column_index[21:17]
    output logic [23:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int RAD_W = $clog2(MAX_RADIUS + 1);
    localparam int CW    = RAD_W + 1;
    localparam int TW    = CW + 21;
    localparam int SUM_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1)) + 33;
    localparam int SQ_W  = $clog2(cpk_pkg::SQUARINGS);

    localparam logic signed [TW-1:0] POS_LIM = TW'(16384);
    localparam logic signed [TW-1:0] NEG_LIM = -TW'(16384);

    // Configuration registers
    logic [3:0]         radius_reg;
    logic signed [15:0] sin1_reg, cos1_reg, sin2_reg, cos2_reg;
    logic [1:0]         quad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 4'd4;
            sin1_reg   <= 16'sd0;
            cos1_reg   <= 16'sd16384;
            sin2_reg   <= 16'sd16384;
            cos2_reg   <= 16'sd0;
            quad_reg   <= 2'd0;
        end else if (cfg_we) begin
            case (cfg_addr)
                cpk_pkg::REG_RADIUS:   radius_reg <= cfg_wdata[3:0];
                cpk_pkg::REG_SIN_1:    sin1_reg   <= cfg_wdata;
                cpk_pkg::REG_COS_1:    cos1_reg   <= cfg_wdata;
                cpk_pkg::REG_SIN_2:    sin2_reg   <= cfg_wdata;
                cpk_pkg::REG_COS_2:    cos2_reg   <= cfg_wdata;
                cpk_pkg::REG_QUADRANT: quad_reg   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state
    cpk_pkg::state_t state_reg, state_next;
    logic                       emit_reg, emit_next;
    logic [RAD_W-1:0]           r_reg, r_next;
    logic [2*RAD_W-1:0]         s2_reg, s2_next;
    logic                       szero_reg, szero_next;
    logic signed [CW-1:0]       x_reg, x_next, y_reg, y_next;
    logic signed [CW-1:0]       yrow_reg, yrow_next;
    logic [4:0]                 col_reg, col_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [cpk_pkg::MUL_W-1:0]  v_reg, v_next, v2_reg, v2_next, v3_reg, v3_next;
    logic [cpk_pkg::MUL_W-1:0]  v4_reg, v4_next, t6_reg, t6_next, e_reg, e_next;
    logic                       ok1_reg, ok1_next;
    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic [16:0]                coef_reg, coef_next;
    logic [1:0]                 stat_reg, stat_next;
    logic                       last_reg, last_next;

    // Shared multiplier with registered product
    logic [cpk_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic [2*cpk_pkg::MUL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    cpk_pkg::div_req_t div_req;
    cpk_pkg::div_rsp_t div_rsp;

    cpk_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Axis distances, scaled by ten
    logic signed [TW-1:0] t1, t2, t1x10, t2x10;
    logic                 neg1, pos1, neg2, pos2, side1_pos, side2_pos, in1, in2;

    assign t1 = TW'(y_reg) * TW'(cos1_reg) - TW'(x_reg) * TW'(sin1_reg);
    assign t2 = TW'(y_reg) * TW'(cos2_reg) - TW'(x_reg) * TW'(sin2_reg);
    assign t1x10 = (t1 <<< 3) + (t1 <<< 1);
    assign t2x10 = (t2 <<< 3) + (t2 <<< 1);
    assign neg1 = (t1x10 <= NEG_LIM);
    assign pos1 = (t1x10 >= POS_LIM);
    assign neg2 = (t2x10 <= NEG_LIM);
    assign pos2 = (t2x10 >= POS_LIM);
    assign side1_pos = quad_reg[1];
    assign side2_pos = quad_reg[1] ^ quad_reg[0];
    assign in1 = side1_pos ? pos1 : neg1;
    assign in2 = side2_pos ? pos2 : neg2;

    // Effective radius and request checks
    logic [RAD_W-1:0] r_eff;
    logic [7:0]       row_ext;
    logic [7:0]       two_r;
    logic [RAD_W-1:0] sigma;
    logic [2*CW-1:0]  d2;
    logic [32:0]      e_poly;
    logic [cpk_pkg::MUL_W-1:0] e_sq;

    assign r_eff   = (32'(radius_reg) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                          : RAD_W'(radius_reg);
    assign row_ext = 8'(s_tdata[4:0]);
    assign two_r   = 8'(r_eff) << 1;
    assign sigma   = r_eff >> 1;
    assign d2      = (2*CW)'(x_reg) * (2*CW)'(x_reg) + (2*CW)'(y_reg) * (2*CW)'(y_reg);
    assign e_poly  = 33'h080000000 - 33'(v_reg) + 33'(v2_reg >> 1) - 33'(t6_reg)
                   + 33'(prod_reg >> cpk_pkg::RECIP24_SH);
    assign e_sq    = cpk_pkg::MUL_W'((prod_reg + 64'h40000000) >> 31);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cpk_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        emit_reg  <= emit_next;
        r_reg     <= r_next;
        s2_reg    <= s2_next;
        szero_reg <= szero_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        yrow_reg  <= yrow_next;
        col_reg   <= col_next;
        sum_reg   <= sum_next;
        v_reg     <= v_next;
        v2_reg    <= v2_next;
        v3_reg    <= v3_next;
        v4_reg    <= v4_next;
        t6_reg    <= t6_next;
        e_reg     <= e_next;
        ok1_reg   <= ok1_next;
        sq_reg    <= sq_next;
        coef_reg  <= coef_next;
        stat_reg  <= stat_next;
        last_reg  <= last_next;
    end

    // Next state and datapath control
    always_comb begin
        state_next = state_reg;
        emit_next  = emit_reg;
        r_next     = r_reg;
        s2_next    = s2_reg;
        szero_next = szero_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        yrow_next  = yrow_reg;
        col_next   = col_reg;
        sum_next   = sum_reg;
        v_next     = v_reg;
        v2_next    = v2_reg;
        v3_next    = v3_reg;
        v4_next    = v4_reg;
        t6_next    = t6_reg;
        e_next     = e_reg;
        ok1_next   = ok1_reg;
        sq_next    = sq_reg;
        coef_next  = coef_reg;
        stat_next  = stat_reg;
        last_next  = last_reg;
        mul_a      = v_reg;
        mul_b      = v_reg;
        div_req.start = 1'b0;
        div_req.num   = cpk_pkg::DIV_W'(d2) << 22;
        div_req.den   = cpk_pkg::DIV_W'(s2_reg);
        div_req.qbits = cpk_pkg::V_QBITS;

        case (state_reg)
            // Take a request, screen the row, start the sum sweep
            cpk_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    r_next     = r_eff;
                    s2_next    = (2*RAD_W)'(sigma) * (2*RAD_W)'(sigma);
                    szero_next = (sigma == '0);
                    x_next     = -CW'(r_eff);
                    y_next     = -CW'(r_eff);
                    col_next   = 5'd0;
                    sum_next   = '0;
                    emit_next  = 1'b0;
                    if (row_ext > two_r) begin
                        coef_next  = '0;
                        stat_next  = cpk_pkg::STAT_BAD_ROW;
                        last_next  = 1'b1;
                        state_next = cpk_pkg::ST_OUT;
                    end else begin
                        state_next = cpk_pkg::ST_AX1;
                    end
                    // Stored row maps to y = r - row
                    yrow_next = CW'(r_eff) - CW'(s_tdata[4:0]);
                end
            end
            cpk_pkg::ST_AX1: begin
                ok1_next   = in1;
                state_next = cpk_pkg::ST_AX2;
            end
            cpk_pkg::ST_AX2: begin
                if (ok1_reg && in2 && !szero_reg) begin
                    div_req.start = 1'b1;
                    state_next    = cpk_pkg::ST_DIVV;
                end else begin
                    e_next     = '0;
                    state_next = cpk_pkg::ST_WDONE;
                end
            end
            cpk_pkg::ST_DIVV: begin
                if (div_rsp.done) begin
                    v_next     = cpk_pkg::MUL_W'(div_rsp.quo);
                    state_next = cpk_pkg::ST_M1;
                end
            end
            // Taylor terms of exp(-v), one multiply per cycle
            cpk_pkg::ST_M1: begin
                state_next = cpk_pkg::ST_M2;
            end
            cpk_pkg::ST_M2: begin
                v2_next    = cpk_pkg::MUL_W'(prod_reg >> 31);
                mul_a      = v2_next;
                state_next = cpk_pkg::ST_M3;
            end
            cpk_pkg::ST_M3: begin
                v3_next    = cpk_pkg::MUL_W'(prod_reg >> 31);
                mul_a      = v3_next;
                state_next = cpk_pkg::ST_M4;
            end
            cpk_pkg::ST_M4: begin
                v4_next    = cpk_pkg::MUL_W'(prod_reg >> 31);
                mul_a      = v3_reg;
                mul_b      = cpk_pkg::RECIP6;
                state_next = cpk_pkg::ST_M5;
            end
            cpk_pkg::ST_M5: begin
                t6_next    = cpk_pkg::MUL_W'(prod_reg >> cpk_pkg::RECIP6_SH);
                mul_a      = v4_reg;
                mul_b      = cpk_pkg::RECIP24;
                state_next = cpk_pkg::ST_M6;
            end
            cpk_pkg::ST_M6: begin
                e_next     = cpk_pkg::MUL_W'(e_poly);
                sq_next    = '0;
                state_next = cpk_pkg::ST_SQ1;
            end
            // Raise to the 256th power by repeated squaring
            cpk_pkg::ST_SQ1: begin
                mul_a      = e_reg;
                mul_b      = e_reg;
                state_next = cpk_pkg::ST_SQ2;
            end
            cpk_pkg::ST_SQ2: begin
                e_next  = e_sq;
                sq_next = sq_reg + SQ_W'(1);
                if (sq_reg == SQ_W'(cpk_pkg::SQUARINGS - 1)) begin
                    state_next = cpk_pkg::ST_WDONE;
                end else begin
                    state_next = cpk_pkg::ST_SQ1;
                end
            end
            // Accumulate, or normalize the emitted weight
            cpk_pkg::ST_WDONE: begin
                if (!emit_reg) begin
                    sum_next = sum_reg + SUM_W'(e_reg);
                    if (x_reg == CW'(r_reg)) begin
                        x_next = -CW'(r_reg);
                        if (y_reg == CW'(r_reg)) begin
                            if (sum_next == '0) begin
                                coef_next  = '0;
                                col_next   = 5'd0;
                                stat_next  = cpk_pkg::STAT_SUM_ZERO;
                                last_next  = 1'b1;
                                state_next = cpk_pkg::ST_OUT;
                            end else begin
                                emit_next  = 1'b1;
                                x_next     = CW'(r_reg);
                                y_next     = yrow_reg;
                                col_next   = 5'd0;
                                state_next = cpk_pkg::ST_AX1;
                            end
                        end else begin
                            y_next     = y_reg + CW'(1);
                            state_next = cpk_pkg::ST_AX1;
                        end
                    end else begin
                        x_next     = x_reg + CW'(1);
                        state_next = cpk_pkg::ST_AX1;
                    end
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = (cpk_pkg::DIV_W'(e_reg) << 16)
                                  + cpk_pkg::DIV_W'(sum_reg >> 1);
                    div_req.den   = cpk_pkg::DIV_W'(sum_reg);
                    div_req.qbits = cpk_pkg::COEF_QBITS;
                    state_next    = cpk_pkg::ST_DIVQ;
                end
            end
            cpk_pkg::ST_DIVQ: begin
                if (div_rsp.done) begin
                    coef_next  = div_rsp.quo[16:0];
                    stat_next  = cpk_pkg::STAT_OK;
                    last_next  = (x_reg == -CW'(r_reg));
                    state_next = cpk_pkg::ST_OUT;
                end
            end
            // Hold the beat until taken
            cpk_pkg::ST_OUT: begin
                if (m_tready) begin
                    if (last_reg) begin
                        state_next = cpk_pkg::ST_IDLE;
                    end else begin
                        col_next   = col_reg + 5'd1;
                        x_next     = x_reg - CW'(1);
                        state_next = cpk_pkg::ST_AX1;
                    end
                end
            end
            default: begin
                state_next = cpk_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == cpk_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == cpk_pkg::ST_OUT);
    assign m_tdata  = {2'b00, col_reg, coef_reg};
    assign m_tuser  = stat_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_R = cpk_pkg::MAX_RADIUS_DEF;

    typedef struct {
        logic [16:0] coefficient;
        logic [4:0]  column_index;
        logic [1:0]  status;
        logic        last_in_row;
    } coef_beat_t;

    logic        aclk;
    logic        aresetn;
    logic [7:0]  s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    corner_prototype_kernel_gen dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Shadow copy of the configuration registers
    logic [3:0]  radius_q;
    logic [15:0] sin1_q, cos1_q, sin2_q, cos2_q;
    logic [1:0]  quad_q;

    logic [4:0]  row_queue[$];
    coef_beat_t  coef_expect[$];
    int          fail_count;
    bit          in_taken;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #400ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic bit axis_side(longint t, bit positive);
        return positive ? (10 * t >= 16384) : (10 * t <= -16384);
    endfunction

    function automatic bit in_corner(int x, int y);
        longint t1, t2;
        t1 = -longint'(x) * longint'($signed(sin1_q)) + longint'(y) * longint'($signed(cos1_q));
        t2 = -longint'(x) * longint'($signed(sin2_q)) + longint'(y) * longint'($signed(cos2_q));
        case (quad_q)
            2'd0: return axis_side(t1, 0) && axis_side(t2, 0);
            2'd1: return axis_side(t1, 0) && axis_side(t2, 1);
            2'd2: return axis_side(t1, 1) && axis_side(t2, 1);
            default: return axis_side(t1, 1) && axis_side(t2, 0);
        endcase
    endfunction

    // Gaussian weight in Q31: Taylor series of exp(-d/256) raised to the 256th power
    function automatic longint unsigned gauss_weight(int x, int y, int sigma);
        longint unsigned d2, v, v2, v3, v4, e;
        if (sigma <= 0 || !in_corner(x, y)) return 0;
        d2 = longint'(x * x + y * y);
        v  = (d2 << 22) / longint'(sigma * sigma);
        v2 = (v * v) >> 31;
        v3 = (v2 * v) >> 31;
        v4 = (v3 * v) >> 31;
        e  = 64'd2147483648 - v + (v2 >> 1) - v3 / 6 + v4 / 24;
        for (int i = 0; i < 8; i++) e = (e * e + 64'd1073741824) >> 31;
        return e;
    endfunction

    function automatic void predict_row(logic [4:0] row);
        int r, sigma, n, y;
        longint unsigned total, w;
        coef_beat_t b;
        r = (int'(radius_q) > MAX_R) ? MAX_R : int'(radius_q);
        sigma = r / 2;
        if (int'(row) > 2 * r) begin
            b = '{17'd0, 5'd0, cpk_pkg::STAT_BAD_ROW, 1'b1};
            coef_expect.push_back(b);
            return;
        end
        total = 0;
        for (int yy = -r; yy <= r; yy++)
            for (int xx = -r; xx <= r; xx++) total += gauss_weight(xx, yy, sigma);
        if (total == 0) begin
            b = '{17'd0, 5'd0, cpk_pkg::STAT_SUM_ZERO, 1'b1};
            coef_expect.push_back(b);
            return;
        end
        y = r - int'(row);
        n = 2 * r + 1;
        for (int c = 0; c < n; c++) begin
            w = gauss_weight(r - c, y, sigma);
            b.coefficient  = 17'((w * 65536 + total / 2) / total);
            b.column_index = 5'(c);
            b.status       = cpk_pkg::STAT_OK;
            b.last_in_row  = (c == n - 1);
            coef_expect.push_back(b);
        end
    endfunction

    // Driver: present queued rows, predict on each accepted beat
    int src_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
            in_taken = 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // hold the beat
        end else begin
            in_taken = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (row_queue.size() > 0) begin
                s_tdata  <= {3'b0, row_queue.pop_front()};
                s_tvalid <= 1'b1;
                src_gap = gap_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            in_taken = 1'b1;
            predict_row(s_tdata[4:0]);
        end
    end

    // Sink stall pattern
    int sink_gap;
    always @(negedge aclk) begin
        if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            sink_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        coef_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (coef_expect.size() == 0) begin
                $error("unexpected result beat %h", m_tdata);
                fail_count++;
            end else begin
                want = coef_expect.pop_front();
                if (m_tdata[16:0] !== want.coefficient) begin
                    $error("coefficient: expected %0d, got %0d", want.coefficient, m_tdata[16:0]);
                    fail_count++;
                end
                if (m_tdata[21:17] !== want.column_index) begin
                    $error("column_index: expected %0d, got %0d",
                           want.column_index, m_tdata[21:17]);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tlast !== want.last_in_row) begin
                    $error("last_in_row: expected %0d, got %0d", want.last_in_row, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (row_queue.size() > 0 || s_tvalid || coef_expect.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            cpk_pkg::REG_RADIUS: radius_q = val[3:0];
            cpk_pkg::REG_SIN_1:  sin1_q = val;
            cpk_pkg::REG_COS_1:  cos1_q = val;
            cpk_pkg::REG_SIN_2:  sin2_q = val;
            cpk_pkg::REG_COS_2:  cos2_q = val;
            default:             quad_q = val[1:0];
        endcase
    endtask

    task automatic set_angles(int a1, int a2);
        real p1, p2;
        p1 = a1 * 3.14159265 / 180.0;
        p2 = a2 * 3.14159265 / 180.0;
        write_reg(cpk_pkg::REG_SIN_1, 16'($rtoi($sin(p1) * 16384.0)));
        write_reg(cpk_pkg::REG_COS_1, 16'($rtoi($cos(p1) * 16384.0)));
        write_reg(cpk_pkg::REG_SIN_2, 16'($rtoi($sin(p2) * 16384.0)));
        write_reg(cpk_pkg::REG_COS_2, 16'($rtoi($cos(p2) * 16384.0)));
    endtask

    initial begin
        int r;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        fail_count = 0;
        sink_gap  = 0;
        radius_q = 4; sin1_q = 0; cos1_q = 16384; sin2_q = 16384; cos2_q = 0; quad_q = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset settings, row extremes and out-of-range rows
        row_queue = '{5'd0, 5'd4, 5'd8, 5'd9, 5'd31, 5'd3};
        wait_drained();
        // Every quadrant at radius 2, plus radius 0 and 1 (sigma zero)
        write_reg(cpk_pkg::REG_RADIUS, 16'd2);
        for (int q = 0; q < 4; q++) begin
            write_reg(cpk_pkg::REG_QUADRANT, 16'(q));
            row_queue = '{5'd0, 5'd2, 5'd4, 5'd5};
            wait_drained();
        end
        write_reg(cpk_pkg::REG_RADIUS, 16'd0);
        row_queue = '{5'd0, 5'd1};
        wait_drained();
        write_reg(cpk_pkg::REG_RADIUS, 16'd1);
        row_queue = '{5'd1};
        wait_drained();
        // Parallel axes give an empty quadrant; extreme register values
        write_reg(cpk_pkg::REG_RADIUS, 16'd3);
        set_angles(0, 0);
        write_reg(cpk_pkg::REG_QUADRANT, 16'd1);
        row_queue = '{5'd3};
        wait_drained();
        write_reg(cpk_pkg::REG_SIN_1, 16'h8000);
        write_reg(cpk_pkg::REG_COS_1, 16'h7FFF);
        write_reg(cpk_pkg::REG_SIN_2, 16'hFFFF);
        write_reg(cpk_pkg::REG_COS_2, 16'h4000);
        write_reg(cpk_pkg::REG_QUADRANT, 16'd3);
        row_queue = '{5'd0, 5'd6};
        wait_drained();
        write_reg(cpk_pkg::REG_RADIUS, 16'd15);
        write_reg(cpk_pkg::REG_QUADRANT, 16'd2);
        set_angles(30, 120);
        row_queue = '{5'd30, 5'd15, 5'd31};
        wait_drained();

        // Random phases: mostly small radii, valid rows, a few bad rows
        for (int ph = 0; ph < 22; ph++) begin
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 15) : $urandom_range(2, 5);
            write_reg(cpk_pkg::REG_RADIUS, 16'(r));
            write_reg(cpk_pkg::REG_QUADRANT, 16'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) == 0) begin
                write_reg(cpk_pkg::REG_SIN_1, 16'($urandom));
                write_reg(cpk_pkg::REG_COS_1, 16'($urandom));
                write_reg(cpk_pkg::REG_SIN_2, 16'($urandom));
                write_reg(cpk_pkg::REG_COS_2, 16'($urandom));
            end else begin
                set_angles($urandom_range(0, 359), $urandom_range(0, 359));
            end
            for (int i = 0; i < ((r > 9) ? 3 : 14); i++)
                row_queue.push_back(($urandom_range(0, 7) == 0) ? 5'($urandom) :
                                    5'($urandom_range(0, 2 * r)));
            wait_drained();
        end
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
